// File: rtl/dssm_pkg.sv
// Shared types and constants of the two-stack word memory.
package dssm_pkg;

  // Default sizes
  localparam int DepthDef    = 256;
  localparam int WordBitsDef = 32;

  // Fixed field widths
  localparam int CapW   = 9;
  localparam int FuncW  = 2;
  localparam int StatW  = 2;
  localparam int ValW   = 32;
  localparam int MDataW = 56;

  // Operation codes
  localparam logic [FuncW-1:0] FnPushLo = 2'd0;
  localparam logic [FuncW-1:0] FnPushHi = 2'd1;
  localparam logic [FuncW-1:0] FnPopLo  = 2'd2;
  localparam logic [FuncW-1:0] FnPopHi  = 2'd3;

  // Status codes
  localparam logic [StatW-1:0] StOk        = 2'd0;
  localparam logic [StatW-1:0] StOverflow  = 2'd1;
  localparam logic [StatW-1:0] StUnderflow = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;  // run the accepted item against counts and memory
    logic load;  // move the finished result into the output register
  } cmd_t;

endpackage

// File: rtl/dual_stack_shared_memory.sv
// Two stacks in one word memory: low stack grows up, high stack grows down.
// An accepted item is decided and its memory access issued, then the result
//   is loaded into the output register once that register is free.
// A new item is taken only after the last result is loaded, as the single
//   memory port and the registered read require; a stalled output holds input.
// Reset: both stacks empty, capacity set to the memory depth (at most 511);
//   memory contents are not cleared, and no entry is read before it is written.
module dual_stack_shared_memory
  import dssm_pkg::*;
#(
  parameter int DEPTH     = DepthDef,
  parameter int WORD_BITS = WordBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Capacity write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CapW-1:0]   cfg_data_i,
  // Input items
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [ValW-1:0]   s_tdata,   // [31:0] push_value
  input  logic [FuncW-1:0]  s_tuser,   // [1:0] func
  // Result items
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [MDataW-1:0] m_tdata,   // [31:0] pop_value, [40:32] low_depth,
                                       // [49:41] high_depth, [55:50] zero
  output logic [StatW-1:0]  m_tuser    // [1:0] status
);

  cmd_t            cmd;
  logic [ValW-1:0] pop_value;
  logic [CapW-1:0] low_depth;
  logic [CapW-1:0] high_depth;

  assign cfg_ready_o = 1'b1;

  dssm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd_o    (cmd)
  );

  dssm_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (s_tuser),
    .push_value_i (s_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .status_o     (m_tuser),
    .pop_value_o  (pop_value),
    .low_depth_o  (low_depth),
    .high_depth_o (high_depth)
  );

  // Pack result fields, lowest first
  assign m_tdata = {{(MDataW - ValW - 2 * CapW){1'b0}}, high_depth, low_depth, pop_value};

endmodule

// File: rtl/dssm_ctrl.sv
// Controller: input/output handshake sequencing for the two-stack memory.
module dssm_ctrl
  import dssm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  // Output register is free when empty or drained this cycle
  assign out_free = !ovalid_q || m_tready;
  assign s_tready = (state_q == S_IDLE);
  assign m_tvalid = ovalid_q;

  // Sequence one item at a time
  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q && !m_tready;
    cmd_o.exec = 1'b0;
    cmd_o.load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_o.exec = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // An accepted item always moves on to the finish step
  a_exec_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=> (state_q == S_FIN))
    else $error("accepted item did not reach finish step");

  // Never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> out_free)
    else $error("result loaded over a pending one");

  // Execute and load never coincide
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.exec && cmd_o.load))
    else $error("exec and load in the same cycle");

endmodule

// File: rtl/dssm_dpath.sv
// Datapath: capacity, stack counts, shared word memory and result register.
module dssm_dpath
  import dssm_pkg::*;
#(
  parameter int DEPTH     = DepthDef,
  parameter int WORD_BITS = WordBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [ValW-1:0]  push_value_i,
  input  logic             cfg_we_i,
  input  logic [CapW-1:0]  cfg_data_i,
  output logic [StatW-1:0] status_o,
  output logic [ValW-1:0]  pop_value_o,
  output logic [CapW-1:0]  low_depth_o,
  output logic [CapW-1:0]  high_depth_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IdxW  = (AddrW > CapW) ? AddrW : CapW;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic [CapW-1:0]      cap_q;
  logic [CapW-1:0]      low_q, low_d;
  logic [CapW-1:0]      high_q, high_d;
  logic [StatW-1:0]     stat_q, stat_d;
  logic                 popok_q, popok_d;
  logic [CapW-1:0]      usable;
  logic [CapW:0]        used;
  logic                 full;
  logic [CapW-1:0]      idx;
  logic [IdxW-1:0]      idx_wide;
  logic [AddrW-1:0]     addr;
  logic                 we;
  logic                 re;
  logic [63:0]          rd_ext;

  // Clamp capacity to the memory size
  assign usable = (32'(cap_q) > 32'(DEPTH)) ? CapW'(DEPTH) : cap_q;
  assign used   = {1'b0, low_q} + {1'b0, high_q};
  assign full   = used >= {1'b0, usable};

  // Decide the item and pick the memory entry it touches
  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    stat_d  = StOk;
    popok_d = 1'b0;
    idx     = low_q;
    we      = 1'b0;
    re      = 1'b0;
    unique case (func_i)
      FnPushLo: begin
        if (full) begin
          stat_d = StOverflow;
        end else begin
          idx   = low_q;
          we    = 1'b1;
          low_d = low_q + 1'b1;
        end
      end
      FnPushHi: begin
        if (full) begin
          stat_d = StOverflow;
        end else begin
          idx    = usable - high_q - 1'b1;
          we     = 1'b1;
          high_d = high_q + 1'b1;
        end
      end
      FnPopLo: begin
        if (low_q == '0) begin
          stat_d = StUnderflow;
        end else begin
          idx     = low_q - 1'b1;
          re      = 1'b1;
          popok_d = 1'b1;
          low_d   = low_q - 1'b1;
        end
      end
      FnPopHi: begin
        if (high_q == '0 || high_q > usable) begin
          stat_d = StUnderflow;
        end else begin
          idx     = usable - high_q;
          re      = 1'b1;
          popok_d = 1'b1;
          high_d  = high_q - 1'b1;
        end
      end
      default: stat_d = StOk;
    endcase
  end

  assign idx_wide = IdxW'(idx);
  assign addr     = idx_wide[AddrW-1:0];

  // Shared word memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem_q[addr] <= WORD_BITS'($unsigned(push_value_i));
    end
    if (cmd_i.exec && re) begin
      rd_q <= mem_q[addr];
    end
  end

  // Capacity and stack counts; a capacity write empties both stacks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapW'(DEPTH > 511 ? 511 : DEPTH);
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_data_i;
      low_q  <= '0;
      high_q <= '0;
    end else if (cmd_i.exec) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // Hold the item's outcome until the result is loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      stat_q  <= stat_d;
      popok_q <= popok_d;
    end
  end

  assign rd_ext = 64'($signed(rd_q));

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o     <= stat_q;
      pop_value_o  <= popok_q ? rd_ext[ValW-1:0] : '0;
      low_depth_o  <= low_q;
      high_depth_o <= high_q;
    end
  end

endmodule

// File: test/dual_stack_shared_memory_tb.sv
// Self-checking testbench for the two-stack shared word memory.
module dual_stack_shared_memory_tb;
  import dssm_pkg::*;

  localparam int LoDepthLsb = ValW;
  localparam int HiDepthLsb = ValW + CapW;
  localparam int StallLimit = 1000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CapW-1:0]   cfg_data_i  = '0;
  logic              s_tvalid    = 1'b0;
  logic              s_tready;
  logic [ValW-1:0]   s_tdata     = '0;   // [31:0] push_value
  logic [FuncW-1:0]  s_tuser     = FnPushLo;  // [1:0] func
  logic              m_tvalid;
  logic              m_tready    = 1'b0;
  logic [MDataW-1:0] m_tdata;            // [31:0] pop_value, [40:32] low_depth,
                                         // [49:41] high_depth, [55:50] zero
  logic [StatW-1:0]  m_tuser;            // [1:0] status

  logic idle_en   = 1'b1;
  int   cfg_count = 0;
  int   stall_cnt = 0;

  typedef struct {
    logic [StatW-1:0] status;
    logic [ValW-1:0]  pop_word;
    logic [CapW-1:0]  low_depth;
    logic [CapW-1:0]  high_depth;
  } stack_result_t;

  // Track both stacks and queue the expected status, pop word and depths per item
  class stack_scoreboard;
    logic [ValW-1:0] words [DepthDef];
    int              low_cnt  = 0;
    int              high_cnt = 0;
    int              capacity = DepthDef;
    stack_result_t   want_q [$];
    int              errors    = 0;
    int              items     = 0;
    int              overflows = 0;
    int              underflows = 0;

    function void set_capacity(logic [CapW-1:0] value);
      capacity = value;
      low_cnt  = 0;
      high_cnt = 0;
    endfunction

    function void note_item(logic [FuncW-1:0] func, logic [ValW-1:0] value);
      stack_result_t r;
      int            usable;
      logic          full;
      usable     = (capacity > DepthDef) ? DepthDef : capacity;
      full       = (low_cnt + high_cnt) >= usable;
      r.status   = StOk;
      r.pop_word = '0;
      case (func)
        FnPushLo: begin
          if (full) r.status = StOverflow;
          else begin
            words[low_cnt] = value;
            low_cnt++;
          end
        end
        FnPushHi: begin
          if (full) r.status = StOverflow;
          else begin
            high_cnt++;
            words[usable - high_cnt] = value;
          end
        end
        FnPopLo: begin
          if (low_cnt == 0) r.status = StUnderflow;
          else begin
            low_cnt--;
            r.pop_word = words[low_cnt];
          end
        end
        default: begin
          if (high_cnt == 0 || high_cnt > usable) r.status = StUnderflow;
          else begin
            r.pop_word = words[usable - high_cnt];
            high_cnt--;
          end
        end
      endcase
      if (r.status == StOverflow) overflows++;
      if (r.status == StUnderflow) underflows++;
      r.low_depth  = low_cnt[CapW-1:0];
      r.high_depth = high_cnt[CapW-1:0];
      want_q.push_back(r);
      items++;
    endfunction

    function void check_result(logic [StatW-1:0] status, logic [MDataW-1:0] data);
      stack_result_t want;
      logic [ValW-1:0] pop_word;
      logic [CapW-1:0] lo;
      logic [CapW-1:0] hi;
      pop_word = data[ValW-1:0];
      lo       = data[LoDepthLsb +: CapW];
      hi       = data[HiDepthLsb +: CapW];
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d pop %h low %0d high %0d",
                                   status, pop_word, lo, hi);
        return;
      end
      want = want_q.pop_front();
      if (status !== want.status || pop_word !== want.pop_word ||
          lo !== want.low_depth || hi !== want.high_depth) begin
        errors++;
        if (errors <= 10)
          $display("mismatch (exp/act): status %0d/%0d pop %h/%h low %0d/%0d high %0d/%0d",
                   want.status, status, want.pop_word, pop_word,
                   want.low_depth, lo, want.high_depth, hi);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  stack_scoreboard sb = new();

  dual_stack_shared_memory dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_tready <= !(idle_en && $urandom_range(99) < 6);
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Abort when no handshake completes for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("** dual_stack_shared_memory: FAILED **");
      $finish;
    end
  end

  // Send one item; keep valid high into the next item unless a gap is taken
  task automatic send_item(logic [FuncW-1:0] func, logic [ValW-1:0] value);
    if (idle_en && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
    sb.note_item(func, value);
  endtask

  // Drain outstanding results, then write the capacity
  task automatic write_capacity(logic [CapW-1:0] value);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_capacity(value);
    cfg_count++;
  endtask

  // Pick a push word, leaning on the sign, all-ones and zero corners now and then
  function automatic logic [ValW-1:0] pick_word();
    case ($urandom_range(11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  int phase_cap [8] = '{511, 1, 0, 2, 256, 5, 0, 257};
  int phase_len [8] = '{270, 15, 8, 15, 25, 20, 25, 12};
  int phase_push[8] = '{100, 50, 50, 50, 55, 50, 50, 60};

  initial begin
    logic [FuncW-1:0] func;
    int               cap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops, sign corners on both stacks, LIFO order
    send_item(FnPopLo, 32'h0);
    send_item(FnPopHi, 32'h0);
    send_item(FnPushLo, 32'h8000_0000);
    send_item(FnPushLo, 32'h7FFF_FFFF);
    send_item(FnPushHi, 32'hFFFF_FFFF);
    send_item(FnPushHi, 32'h0000_0000);
    send_item(FnPopHi, 32'h0);
    send_item(FnPopLo, 32'h0);
    send_item(FnPopHi, 32'h0);
    send_item(FnPopLo, 32'h0);
    send_item(FnPopLo, 32'h0);
    // Zero capacity: nothing is usable
    write_capacity(9'd0);
    send_item(FnPushLo, 32'h1234_5678);
    send_item(FnPushHi, 32'h8765_4321);
    send_item(FnPopHi, 32'h0);
    // Single entry shared by both stacks
    write_capacity(9'd1);
    send_item(FnPushHi, 32'h5A5A_A5A5);
    send_item(FnPushLo, 32'hA5A5_5A5A);
    send_item(FnPopLo, 32'h0);
    send_item(FnPopHi, 32'h0);
    // Stacks meet in the middle
    write_capacity(9'd2);
    send_item(FnPushLo, 32'h0000_0001);
    send_item(FnPushHi, 32'hFFFF_FFFE);
    send_item(FnPushHi, 32'h0000_0002);
    send_item(FnPopLo, 32'h0);
    send_item(FnPopHi, 32'h0);
    // Capacity beyond the memory saturates
    write_capacity(9'd511);
    send_item(FnPushHi, 32'h1234_5678);
    send_item(FnPopHi, 32'h0);

    // Random phases over several capacities; the first one fills the memory
    for (int ph = 0; ph < 8; ph++) begin
      cap = (ph == 6) ? $urandom_range(40, 3) : phase_cap[ph];
      write_capacity(cap[CapW-1:0]);
      for (int k = 0; k < phase_len[ph]; k++) begin
        idle_en <= !(ph == 0 && k < 150);
        if ($urandom_range(99) < phase_push[ph])
          func = $urandom_range(1) ? FnPushHi : FnPushLo;
        else
          func = $urandom_range(1) ? FnPopHi : FnPopLo;
        send_item(func, pick_word());
      end
    end
    s_tvalid <= 1'b0;
    idle_en  <= 1'b1;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("ran %0d items over %0d capacity settings, 0 through saturated",
             sb.items, cfg_count);
    $display("saw %0d overflows and %0d underflows, %0d mismatches",
             sb.overflows, sb.underflows, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** dual_stack_shared_memory: PASSED **");
    end else begin
      $display("** dual_stack_shared_memory: FAILED **");
    end
    $finish;
  end

endmodule
